// ----- rtl/core/kvc_pkg.sv -----
// Shared types and constants for the key-value cache responder.
// Used by kvc_match, kvc_slot_store, key_value_cache_responder and the testbench; no dependencies.
package kvc_pkg;

    // Number of key registers on the configuration port and the default slot count
    localparam int NUM_KEY_REGS  = 8;
    localparam int DEFAULT_SLOTS = 8;
    localparam int KEY_IDX_W     = $clog2(NUM_KEY_REGS);

    // Field widths
    localparam int OP_W       = 8;
    localparam int KEY_W      = 48;
    localparam int KEY_SLOT_W = 49;
    localparam int IN_USE_BIT = 48;
    localparam int VALUE_W    = 32;
    localparam int IP_W       = 32;
    localparam int PORT_W     = 16;

    // Stream payload widths
    localparam int S_TDATA_W = KEY_W + VALUE_W + 2 * IP_W + 2 * PORT_W;
    localparam int M_TDATA_W = VALUE_W + 2 * IP_W + 2 * PORT_W;
    localparam int S_TUSER_W = 8;
    localparam int M_TUSER_W = 16;

    // Configuration port: 64-bit registers at byte address 8*i
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = KEY_IDX_W + 3;

    // Opcodes
    localparam logic [OP_W-1:0] OP_READ    = 8'd1;
    localparam logic [OP_W-1:0] OP_INVAL   = 8'd2;
    localparam logic [OP_W-1:0] OP_WRITE_A = 8'd3;
    localparam logic [OP_W-1:0] OP_WRITE_B = 8'd4;
    localparam logic [OP_W-1:0] OP_REPLY   = 8'd5;

    typedef logic [KEY_SLOT_W-1:0] key_slot_t;

    // Result of the parallel key compare
    typedef struct packed {
        logic                 hit;
        logic [KEY_IDX_W-1:0] idx;
    } slot_hit_t;

    // Slot state update issued when a request leaves the input register
    typedef struct packed {
        logic                 en;
        logic                 set_valid;
        logic                 store;
        logic [KEY_IDX_W-1:0] idx;
        logic [VALUE_W-1:0]   value;
    } slot_upd_t;

endpackage

// ----- rtl/core/kvc_match.sv -----
// Parallel key compare with lowest-slot priority.
// Depends on kvc_pkg.
module kvc_match
    import kvc_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
)
(
    input  key_slot_t [NUM_KEY_REGS-1:0] key_slots,
    input  logic [KEY_W-1:0]             request_key,
    output slot_hit_t                    slot_hit
);

    logic [SLOTS-1:0] match_vec;

    // One comparator per slot; a slot not in use never matches
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            match_vec[i] = key_slots[i][IN_USE_BIT] &&
                           (key_slots[i][KEY_W-1:0] == request_key);
        end
    end

    // Priority encoder: the lowest matching slot wins
    always_comb
    begin
        slot_hit = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                slot_hit.hit = 1'b1;
                slot_hit.idx = KEY_IDX_W'(i);
            end
        end
    end

endmodule

// ----- rtl/core/kvc_slot_store.sv -----
// Key registers with their APB write/read port, slot valid bits and cached values.
// Depends on kvc_pkg.
module kvc_slot_store
    import kvc_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready,
    input  slot_upd_t                     upd,
    input  logic [KEY_IDX_W-1:0]          rd_idx,
    output logic                          rd_valid,
    output logic [VALUE_W-1:0]            rd_value,
    output key_slot_t [NUM_KEY_REGS-1:0]  key_slots
);

    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    key_slot_t [NUM_KEY_REGS-1:0] key_slot_reg;
    logic [SLOTS-1:0]             slot_valid_reg;
    logic [VALUE_W-1:0]           slot_value_reg [SLOTS];
    logic                         cfg_wr;
    logic [KEY_IDX_W-1:0]         cfg_idx;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = paddr[APB_ADDR_W-1:3];
    assign key_slots = key_slot_reg;
    assign prdata   = APB_DATA_W'(key_slot_reg[cfg_idx]);

    // Key registers, written by an APB transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_slot_reg <= '0;
        end
        else if (cfg_wr)
        begin
            key_slot_reg[cfg_idx] <= pwdata[KEY_SLOT_W-1:0];
        end
    end

    // Valid bits: a rewritten key drops its cached value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (cfg_wr && (cfg_idx == KEY_IDX_W'(i)))
                begin
                    slot_valid_reg[i] <= 1'b0;
                end
                else if (upd.en && (upd.idx == KEY_IDX_W'(i)))
                begin
                    slot_valid_reg[i] <= upd.set_valid;
                end
            end
        end
    end

    // Cached values; only read while the slot is valid
    always_ff @(posedge clk)
    begin
        if (upd.en && upd.store)
        begin
            slot_value_reg[upd.idx[SLOT_IDX_W-1:0]] <= upd.value;
        end
    end

    assign rd_valid = slot_valid_reg[rd_idx[SLOT_IDX_W-1:0]];
    assign rd_value = slot_value_reg[rd_idx[SLOT_IDX_W-1:0]];

    // A stored write leaves its slot valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (upd.en && upd.store && !cfg_wr) |=> slot_valid_reg[$past(upd.idx[SLOT_IDX_W-1:0])])
        else $error("slot not valid after a value was stored");

    // Rewriting a key register clears the valid bit of that slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && (cfg_idx <= KEY_IDX_W'(SLOTS - 1)) ) |=>
            !slot_valid_reg[$past(cfg_idx[SLOT_IDX_W-1:0])])
        else $error("slot still valid after its key was rewritten");

endmodule

// ----- rtl/core/key_value_cache_responder.sv -----
// Top level of the key-value cache responder: input register, slot lookup and result register.
// Depends on kvc_pkg, kvc_match and kvc_slot_store.

// The block takes one parsed request per clock cycle while the output is not stalled and
// gives one result per request. A request is held in an input
// register; from there the 48-bit key is compared against all slots in parallel, the slot
// state is updated and the result is formed in the same cycle, and the result is captured
// in an output register. The slot state changes as the request moves into the output
// register, so the following request already sees it. The user must write the key registers
// over the APB port only while no request is in flight; the block itself does not enforce
// this. Writing a key register drops the value cached for that slot. There is no clearing pass after reset.
module key_value_cache_responder
    import kvc_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // request_key[47:0], request_value[79:48], source_ip[111:80], dest_ip[143:112],
    // source_port[159:144], dest_port[175:160]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // request_op[7:0]
    input  logic [S_TUSER_W-1:0]  s_tuser,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // reply_value[31:0], out_source_ip[63:32], out_dest_ip[95:64],
    // out_source_port[111:96], out_dest_port[127:112]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // reply_op[7:0], turn_back[8], zero fill above
    output logic [M_TUSER_W-1:0]  m_tuser,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Input register
    logic                  in_valid_reg;
    logic [OP_W-1:0]       in_op_reg;
    logic [KEY_W-1:0]      in_key_reg;
    logic [VALUE_W-1:0]    in_value_reg;
    logic [IP_W-1:0]       in_sip_reg;
    logic [IP_W-1:0]       in_dip_reg;
    logic [PORT_W-1:0]     in_sport_reg;
    logic [PORT_W-1:0]     in_dport_reg;

    // Result register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OP_W-1:0]       out_op_reg;
    logic [VALUE_W-1:0]    out_value_reg;
    logic [IP_W-1:0]       out_sip_reg;
    logic [IP_W-1:0]       out_dip_reg;
    logic [PORT_W-1:0]     out_sport_reg;
    logic [PORT_W-1:0]     out_dport_reg;
    logic                  out_turn_reg;

    key_slot_t [NUM_KEY_REGS-1:0] key_slots;
    slot_hit_t             slot_hit;
    slot_upd_t             upd;
    logic                  rd_valid;
    logic [VALUE_W-1:0]    rd_value;
    logic                  advance;
    logic                  is_write;
    logic                  is_reply;

    // The request moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg    <= s_tuser[OP_W-1:0];
            in_key_reg   <= s_tdata[KEY_W-1:0];
            in_value_reg <= s_tdata[KEY_W +: VALUE_W];
            in_sip_reg   <= s_tdata[KEY_W + VALUE_W +: IP_W];
            in_dip_reg   <= s_tdata[KEY_W + VALUE_W + IP_W +: IP_W];
            in_sport_reg <= s_tdata[KEY_W + VALUE_W + 2 * IP_W +: PORT_W];
            in_dport_reg <= s_tdata[KEY_W + VALUE_W + 2 * IP_W + PORT_W +: PORT_W];
        end
    end

    kvc_match #(
        .SLOTS (SLOTS)
    ) u_match (
        .key_slots   (key_slots),
        .request_key (in_key_reg),
        .slot_hit    (slot_hit)
    );

    kvc_slot_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .upd       (upd),
        .rd_idx    (slot_hit.idx),
        .rd_valid  (rd_valid),
        .rd_value  (rd_value),
        .key_slots (key_slots)
    );

    // Opcode decode against the hit slot
    assign is_write = (in_op_reg == OP_WRITE_A) || (in_op_reg == OP_WRITE_B);
    assign is_reply = slot_hit.hit && (in_op_reg == OP_READ) && rd_valid;

    always_comb
    begin
        upd.en        = advance && slot_hit.hit && (is_write || (in_op_reg == OP_INVAL));
        upd.set_valid = is_write;
        upd.store     = is_write;
        upd.idx       = slot_hit.idx;
        upd.value     = in_value_reg;
    end

    // Result register
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // A read hit on a valid slot gets the cached value and swapped endpoints; all else passes through
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (is_reply)
            begin
                out_op_reg    <= OP_REPLY;
                out_value_reg <= rd_value;
                out_sip_reg   <= in_dip_reg;
                out_dip_reg   <= in_sip_reg;
                out_sport_reg <= in_dport_reg;
                out_dport_reg <= in_sport_reg;
                out_turn_reg  <= 1'b1;
            end
            else
            begin
                out_op_reg    <= in_op_reg;
                out_value_reg <= in_value_reg;
                out_sip_reg   <= in_sip_reg;
                out_dip_reg   <= in_dip_reg;
                out_sport_reg <= in_sport_reg;
                out_dport_reg <= in_dport_reg;
                out_turn_reg  <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_dport_reg, out_sport_reg, out_dip_reg, out_sip_reg, out_value_reg};
    assign m_tuser  = {{(M_TUSER_W - OP_W - 1){1'b0}}, out_turn_reg, out_op_reg};

    // A turned-back result always carries the reply opcode
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[OP_W]) |-> (m_tuser[OP_W-1:0] == OP_REPLY))
        else $error("turned-back result without reply opcode");

    // A request leaving the input register is presented on the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("result lost after leaving the input register");

    // A reply carries the request's destination address as its source address
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_reply) |=> (m_tdata[VALUE_W +: IP_W] == $past(in_dip_reg)))
        else $error("reply source address not swapped");

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the key-value cache responder: APB key set-up, directed and
// random request streams with back-pressure, each result checked against a local predictor
// or a result typed in the directed table. Depends on kvc_pkg and key_value_cache_responder.
module testbench;
    import kvc_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int SLOT_COUNT  = DEFAULT_SLOTS;
    localparam int MAX_REPORTS = 10;
    localparam int HOLD_CYCLES = 64;
    localparam int DRAIN_WAIT  = 4;
    localparam int LIMIT_CYCLES = 300000;
    localparam logic [KEY_W-1:0] KEY_ONES = '1;
    localparam logic [KEY_W-1:0] KEY_TWIN = 48'h0123_4567_89AB;
    localparam logic [KEY_W-1:0] KEY_IDLE = 48'h5A5A_A5A5_3C3C;

    // One parsed request and one outgoing header
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [IP_W-1:0]    sip;
        logic [IP_W-1:0]    dip;
        logic [PORT_W-1:0]  sport;
        logic [PORT_W-1:0]  dport;
    } kv_request_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic [IP_W-1:0]    sip;
        logic [IP_W-1:0]    dip;
        logic [PORT_W-1:0]  sport;
        logic [PORT_W-1:0]  dport;
        logic               turn_back;
    } kv_header_t;

    // How a directed row is checked: by the predictor, or by a result typed in the table
    typedef enum logic [1:0] {CHECK_MODEL, CHECK_PASS, CHECK_REPLY} check_kind_t;

    typedef struct packed {
        kv_request_t        rq;
        check_kind_t        kind;
        logic [VALUE_W-1:0] cached;
    } stim_row_t;

    // Ways of filling the key registers between phases
    typedef enum int {KEYS_EXTREME, KEYS_ALL_LIVE, KEYS_NONE_LIVE, KEYS_MIXED} key_plan_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor copy of the key registers and the slot state
    key_slot_t          key_copy   [NUM_KEY_REGS];
    bit                 slot_live  [NUM_KEY_REGS];
    logic [VALUE_W-1:0] slot_data  [NUM_KEY_REGS];

    kv_header_t headers_due[$];
    stim_row_t  directed_rows[$];

    int requests_sent;
    int cache_answers;
    int key_writes;
    int mismatches;
    bit src_gaps;
    bit sink_gaps;
    bit hold_req;

    key_value_cache_responder #(.SLOTS(SLOT_COUNT)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    // A request that leaves the cache untouched comes out as it went in.
    function automatic kv_header_t pass_through(kv_request_t rq);
        kv_header_t h;
        h.op        = rq.op;
        h.value     = rq.value;
        h.sip       = rq.sip;
        h.dip       = rq.dip;
        h.sport     = rq.sport;
        h.dport     = rq.dport;
        h.turn_back = 1'b0;
        return h;
    endfunction

    // A read served from the cache is sent back with addresses and ports exchanged.
    function automatic kv_header_t turned_round(kv_request_t rq, logic [VALUE_W-1:0] stored);
        kv_header_t h;
        h.op        = OP_REPLY;
        h.value     = stored;
        h.sip       = rq.dip;
        h.dip       = rq.sip;
        h.sport     = rq.dport;
        h.dport     = rq.sport;
        h.turn_back = 1'b1;
        return h;
    endfunction

    // Looks the key up in the slots, updates the slot state and forms the outgoing header.
    function automatic kv_header_t answer_request(kv_request_t rq);
        int         hit;
        kv_header_t h;
        hit = -1;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (key_copy[i][IN_USE_BIT] && key_copy[i][KEY_W-1:0] == rq.key)
                hit = i;
        end
        h = pass_through(rq);
        if (hit >= 0)
        begin
            if (rq.op == OP_INVAL)
                slot_live[hit] = 1'b0;
            else if (rq.op == OP_WRITE_A || rq.op == OP_WRITE_B)
            begin
                slot_live[hit] = 1'b1;
                slot_data[hit] = rq.value;
            end
            else if (rq.op == OP_READ && slot_live[hit])
                h = turned_round(rq, slot_data[hit]);
        end
        return h;
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        return {16'($urandom()), $urandom()};
    endfunction

    // Mostly well-formed traffic on configured keys, with near misses and random noise.
    function automatic kv_request_t make_request();
        kv_request_t rq;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            rq.key = key_copy[$urandom_range(0, NUM_KEY_REGS - 1)][KEY_W-1:0];
        else if (pick == 6)
            rq.key = key_copy[$urandom_range(0, NUM_KEY_REGS - 1)][KEY_W-1:0]
                     ^ (48'd1 << $urandom_range(0, KEY_W - 1));
        else
            rq.key = random_key();
        pick = $urandom_range(0, 19);
        if (pick < 8)
            rq.op = OP_READ;
        else if (pick < 11)
            rq.op = OP_WRITE_A;
        else if (pick < 14)
            rq.op = OP_WRITE_B;
        else if (pick < 16)
            rq.op = OP_INVAL;
        else
            rq.op = 8'($urandom_range(0, 255));
        rq.value = $urandom();
        rq.sip   = $urandom();
        rq.dip   = $urandom();
        rq.sport = 16'($urandom());
        rq.dport = 16'($urandom());
        return rq;
    endfunction

    function automatic stim_row_t stim(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                       logic [VALUE_W-1:0] value, logic [IP_W-1:0] sip,
                                       logic [IP_W-1:0] dip, logic [PORT_W-1:0] sport,
                                       logic [PORT_W-1:0] dport, check_kind_t kind,
                                       logic [VALUE_W-1:0] cached);
        stim_row_t r;
        r.rq.op    = op;
        r.rq.key   = key;
        r.rq.value = value;
        r.rq.sip   = sip;
        r.rq.dip   = dip;
        r.rq.sport = sport;
        r.rq.dport = dport;
        r.kind     = kind;
        r.cached   = cached;
        return r;
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(stim_row_t r);
        directed_rows = {directed_rows, r};
    endfunction

    // Offers one request, with an occasional gap before it, and records its expected header
    // once the transfer has taken place.
    task automatic push_request(kv_request_t rq, check_kind_t kind, logic [VALUE_W-1:0] cached);
        kv_header_t h;
        if (src_gaps && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.op;
        s_tdata  <= {rq.dport, rq.sport, rq.dip, rq.sip, rq.value, rq.key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        h = answer_request(rq);
        if (kind == CHECK_PASS)
            h = pass_through(rq);
        else if (kind == CHECK_REPLY)
            h = turned_round(rq, cached);
        if (h.turn_back)
            cache_answers++;
        requests_sent++;
        headers_due = {headers_due, h};
    endtask

    // Stops offering and waits until every outstanding header has come out.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (headers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // One APB transfer; psel stays high so that transfers can follow back to back.
    task automatic apb_access(input bit wr, input int idx, input logic [APB_DATA_W-1:0] data,
                              output logic [APB_DATA_W-1:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'(idx * 8);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_key(int idx, logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] unused;
        apb_access(1'b1, idx, data, unused);
        key_copy[idx]  = data[KEY_SLOT_W-1:0];
        slot_live[idx] = 1'b0;
        key_writes++;
    endtask

    // Reads a key register back; only the 49 register bits are kept.
    task automatic check_key(int idx);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if (rd !== APB_DATA_W'(key_copy[idx]))
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("key register %0d read back: expected %h, got %h",
                         idx, APB_DATA_W'(key_copy[idx]), rd);
        end
    endtask

    // Writes all eight key registers according to the plan, then reads one back.
    task automatic load_keys(key_plan_t plan);
        logic [KEY_W-1:0] key;
        bit               live;
        int               pick;
        for (int i = 0; i < NUM_KEY_REGS; i++)
        begin
            key  = random_key();
            live = 1'b1;
            case (plan)
                KEYS_EXTREME:
                begin
                    if (i == 0)
                        key = '0;
                    else if (i == 1)
                        key = KEY_ONES;
                    else if (i == 2 || i == 3)
                        key = KEY_TWIN;
                    else if (i == 4)
                    begin
                        key  = KEY_IDLE;
                        live = 1'b0;
                    end
                end
                KEYS_ALL_LIVE:
                begin
                    if (i >= 6)
                        key = key_copy[i - 6][KEY_W-1:0];
                end
                KEYS_NONE_LIVE:
                    live = 1'b0;
                default:
                begin
                    pick = $urandom_range(0, 5);
                    if (pick == 0)
                        key = key_copy[i][KEY_W-1:0];
                    else if (pick == 1)
                        key = '0;
                    else if (pick == 2)
                        key = KEY_ONES;
                    else if (pick == 3 && i > 0)
                        key = key_copy[$urandom_range(0, i - 1)][KEY_W-1:0];
                    live = ($urandom_range(0, 3) != 0);
                end
            endcase
            // Bits above the register are driven at random; the block must drop them.
            write_key(i, {15'($urandom()), live, key});
        end
        check_key($urandom_range(0, NUM_KEY_REGS - 1));
        apb_release();
    endtask

    task automatic run_phase(int count, bit gaps, bit with_hold);
        src_gaps  = gaps;
        sink_gaps = gaps;
        for (int k = 0; k < count; k++)
        begin
            if (with_hold && k == count / 4)
                hold_req = 1'b1;
            push_request(make_request(), CHECK_MODEL, '0);
        end
        settle();
    endtask

    // Receiver side: random stall bursts, and one long hold-off when asked for.
    initial
    begin : result_sink
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (sink_gaps && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Each outgoing header is compared field by field with the oldest one due.
    always @(posedge clk)
    begin : header_check
        kv_header_t got;
        kv_header_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.op        = m_tuser[OP_W-1:0];
            got.turn_back = m_tuser[OP_W];
            got.value     = m_tdata[31:0];
            got.sip       = m_tdata[63:32];
            got.dip       = m_tdata[95:64];
            got.sport     = m_tdata[111:96];
            got.dport     = m_tdata[127:112];
            if (headers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected header: op %0d value %h", got.op, got.value);
            end
            else
            begin
                want = headers_due.pop_front();
                if (got.op !== want.op || got.value !== want.value || got.sip !== want.sip
                    || got.dip !== want.dip || got.sport !== want.sport
                    || got.dport !== want.dport || got.turn_back !== want.turn_back)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("expected op %0d value %h ip %h>%h port %h>%h back %b",
                                 want.op, want.value, want.sip, want.dip,
                                 want.sport, want.dport, want.turn_back);
                        $display("     got op %0d value %h ip %h>%h port %h>%h back %b",
                                 got.op, got.value, got.sip, got.dip,
                                 got.sport, got.dport, got.turn_back);
                    end
                end
            end
        end
    end

    // Overall time limit.
    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("** key_value_cache_responder: FAILED **");
        $finish;
    end

    // Main sequence: reset, directed table, then random phases under different key settings.
    initial
    begin : stimulus
        logic [KEY_W-1:0] key5;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        hold_req = 1'b0;
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        requests_sent = 0;
        cache_answers = 0;
        key_writes    = 0;
        mismatches    = 0;
        for (int i = 0; i < NUM_KEY_REGS; i++)
        begin
            key_copy[i]  = '0;
            slot_live[i] = 1'b0;
            slot_data[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every key register reads back as zero after reset.
        for (int i = 0; i < NUM_KEY_REGS; i++)
            check_key(i);
        load_keys(KEYS_EXTREME);
        key5 = key_copy[5][KEY_W-1:0];

        // Directed table: zero key, all-ones key, twin keys, a slot out of use, odd opcodes.
        add_row(stim(OP_READ, '0, '0, '0, '0, '0, '0, CHECK_PASS, '0));
        add_row(stim(OP_WRITE_A, '0, '1, '1, '0, '1, '0, CHECK_PASS, '0));
        add_row(stim(OP_READ, '0, '0, 32'hC0A8_0001, 32'h0A00_0002,
                     16'h1234, 16'h2B67, CHECK_REPLY, 32'hFFFF_FFFF));
        add_row(stim(OP_WRITE_B, KEY_ONES, '0, '0, '1, '0, '1, CHECK_PASS, '0));
        add_row(stim(OP_READ, KEY_ONES, 32'h1234_5678, '1, '1, '1, '1,
                     CHECK_REPLY, '0));
        add_row(stim(OP_INVAL, '0, 32'h0000_0001, 32'h0101_0101,
                     32'h0202_0202, 16'd53, 16'd80, CHECK_PASS, '0));
        add_row(stim(OP_READ, '0, 32'h8000_0000, 32'h0A0A_0A0A,
                     32'h0B0B_0B0B, 16'd1, 16'd2, CHECK_PASS, '0));
        add_row(stim(OP_WRITE_A, KEY_TWIN, 32'hCAFE_0001, 32'h0A00_0001,
                     32'h0A00_0009, 16'd4000, 16'd11211, CHECK_PASS, '0));
        add_row(stim(OP_READ, KEY_TWIN, '0, 32'h0A00_0001, 32'h0A00_0009,
                     16'd4000, 16'd11211, CHECK_REPLY, 32'hCAFE_0001));
        add_row(stim(OP_WRITE_B, KEY_IDLE, 32'h1111_1111, 32'h0A00_0003,
                     32'h0A00_0004, 16'd7, 16'd8, CHECK_PASS, '0));
        add_row(stim(OP_READ, KEY_IDLE, 32'h2222_2222, 32'h0A00_0003,
                     32'h0A00_0004, 16'd7, 16'd8, CHECK_PASS, '0));
        add_row(stim(8'd0, KEY_ONES, 32'h3333_3333, 32'h0A00_0005,
                     32'h0A00_0006, 16'd9, 16'd10, CHECK_PASS, '0));
        add_row(stim(OP_REPLY, KEY_ONES, 32'h4444_4444, 32'h0A00_0005,
                     32'h0A00_0006, 16'd9, 16'd10, CHECK_PASS, '0));
        add_row(stim(8'hFF, KEY_ONES, 32'h5555_5555, 32'h0A00_0005,
                     32'h0A00_0006, 16'd9, 16'd10, CHECK_PASS, '0));
        add_row(stim(OP_READ, KEY_ONES, 32'h6666_6666, 32'h0A00_0005,
                     32'h0A00_0006, 16'd9, 16'd10, CHECK_REPLY, '0));
        add_row(stim(OP_INVAL, KEY_ONES, '0, '0, '0, '0, '0, CHECK_PASS, '0));
        add_row(stim(OP_READ, KEY_ONES, '1, '1, '1, '1, '1, CHECK_PASS, '0));
        add_row(stim(OP_WRITE_A, key5, $urandom(), $urandom(), $urandom(),
                     16'($urandom()), 16'($urandom()), CHECK_MODEL, '0));
        add_row(stim(OP_READ, key5, $urandom(), $urandom(), $urandom(),
                     16'($urandom()), 16'($urandom()), CHECK_MODEL, '0));
        add_row(stim(OP_READ, random_key(), $urandom(), $urandom(), $urandom(),
                     16'($urandom()), 16'($urandom()), CHECK_MODEL, '0));
        // Twin keys: only the lower slot is ever hit, so invalidating it ends the replies.
        add_row(stim(OP_WRITE_B, KEY_TWIN, '0, 32'h0A00_0001, 32'h0A00_0009,
                     16'd5, 16'd6, CHECK_PASS, '0));
        add_row(stim(OP_READ, KEY_TWIN, '1, 32'h0A00_0001, 32'h0A00_0009,
                     16'd5, 16'd6, CHECK_REPLY, '0));
        add_row(stim(OP_INVAL, KEY_TWIN, '0, '0, '0, '0, '0, CHECK_PASS, '0));
        add_row(stim(OP_READ, KEY_TWIN, 32'h7777_7777, 32'h0A00_0001,
                     32'h0A00_0009, 16'd5, 16'd6, CHECK_PASS, '0));

        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        foreach (directed_rows[i])
            push_request(directed_rows[i].rq, directed_rows[i].kind, directed_rows[i].cached);
        settle();

        // Random phases under changing key settings; the third and the last run without gaps.
        load_keys(KEYS_ALL_LIVE);
        run_phase(110, 1'b1, 1'b0);
        load_keys(KEYS_NONE_LIVE);
        run_phase(50, 1'b1, 1'b0);
        load_keys(KEYS_MIXED);
        run_phase(110, 1'b0, 1'b0);
        load_keys(KEYS_MIXED);
        run_phase(110, 1'b1, 1'b1);
        load_keys(KEYS_EXTREME);
        run_phase(110, 1'b0, 1'b0);
        repeat (10) @(posedge clk);

        $display("Covered %0d requests under six key settings, %0d served from the cache.",
                 requests_sent, cache_answers);
        $display("Key register writes: %0d; mismatches: %0d.", key_writes, mismatches);
        if (mismatches == 0 && headers_due.size() == 0)
            $display("** key_value_cache_responder: PASSED **");
        else
            $display("** key_value_cache_responder: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/kvc_pkg.sv
rtl/core/kvc_match.sv
rtl/core/kvc_slot_store.sv
rtl/core/key_value_cache_responder.sv
bench/testbench.sv
